// File: design/grc_pkg.sv
// Shared types, constants and the sine table of the grid raycast column engine.
package grc_pkg;

  localparam int MapCells    = 4096;
  localparam int MapAw       = 12;
  localparam int DepthCells  = 25;
  localparam int ShadeCount  = 20;
  localparam int StepLimit   = DepthCells * 10;
  localparam int QDepth      = 4;

  // register indexes
  localparam logic [2:0] RegPlayerX = 3'd0;
  localparam logic [2:0] RegPlayerY = 3'd1;
  localparam logic [2:0] RegView    = 3'd2;
  localparam logic [2:0] RegFov     = 3'd3;
  localparam logic [2:0] RegScrW    = 3'd4;
  localparam logic [2:0] RegScrH    = 3'd5;
  localparam logic [2:0] RegMapW    = 3'd6;
  localparam logic [2:0] RegMapH    = 3'd7;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdCast  = 1'b1;

  // one queued request from front to back
  typedef struct packed {
    logic        cmd;
    logic [11:0] cell_index;
    logic        cell_wall;
    logic [9:0]  column;
  } req_t;

  // quarter sine, 14 fraction bits
  function automatic logic [14:0] qsin(input logic [6:0] i);
    logic [14:0] v;
    unique case (i)
      7'd0: v = 15'd0;      7'd1: v = 15'd402;    7'd2: v = 15'd804;
      7'd3: v = 15'd1205;   7'd4: v = 15'd1606;   7'd5: v = 15'd2006;
      7'd6: v = 15'd2404;   7'd7: v = 15'd2801;   7'd8: v = 15'd3196;
      7'd9: v = 15'd3590;   7'd10: v = 15'd3981;  7'd11: v = 15'd4370;
      7'd12: v = 15'd4756;  7'd13: v = 15'd5139;  7'd14: v = 15'd5520;
      7'd15: v = 15'd5897;  7'd16: v = 15'd6270;  7'd17: v = 15'd6639;
      7'd18: v = 15'd7005;  7'd19: v = 15'd7366;  7'd20: v = 15'd7723;
      7'd21: v = 15'd8076;  7'd22: v = 15'd8423;  7'd23: v = 15'd8765;
      7'd24: v = 15'd9102;  7'd25: v = 15'd9434;  7'd26: v = 15'd9760;
      7'd27: v = 15'd10080; 7'd28: v = 15'd10394; 7'd29: v = 15'd10702;
      7'd30: v = 15'd11003; 7'd31: v = 15'd11297; 7'd32: v = 15'd11585;
      7'd33: v = 15'd11866; 7'd34: v = 15'd12140; 7'd35: v = 15'd12406;
      7'd36: v = 15'd12665; 7'd37: v = 15'd12916; 7'd38: v = 15'd13160;
      7'd39: v = 15'd13395; 7'd40: v = 15'd13623; 7'd41: v = 15'd13842;
      7'd42: v = 15'd14053; 7'd43: v = 15'd14256; 7'd44: v = 15'd14449;
      7'd45: v = 15'd14635; 7'd46: v = 15'd14811; 7'd47: v = 15'd14978;
      7'd48: v = 15'd15137; 7'd49: v = 15'd15286; 7'd50: v = 15'd15426;
      7'd51: v = 15'd15557; 7'd52: v = 15'd15679; 7'd53: v = 15'd15791;
      7'd54: v = 15'd15893; 7'd55: v = 15'd15986; 7'd56: v = 15'd16069;
      7'd57: v = 15'd16143; 7'd58: v = 15'd16207; 7'd59: v = 15'd16261;
      7'd60: v = 15'd16305; 7'd61: v = 15'd16340; 7'd62: v = 15'd16364;
      7'd63: v = 15'd16379; 7'd64: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/grid_raycast_column.sv
// Grid raycast column engine: front, request queue and marching back end.
// Write requests store one wall bit in the back end's map store as they leave the
// queue. A cast request runs the angle division, the STrig and SPos setup states,
// then marches m steps (at most 250), each through SChk, SRead and SOut around the
// one map-store read per step, then the slice division; its result strobe is
// registered from the end of the slice division. Results come as a one-cycle strobe
// and cannot be held off. Up to four requests wait in the queue; busy is high while it is full.
module grid_raycast_column import grc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [11:0] cell_index_i,
  input  logic        cell_wall_i,
  input  logic [9:0]  column_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [9:0]  column_out_o,
  output logic        hit_o,
  output logic [7:0]  step_count_o,
  output logic [9:0]  ceiling_row_o,
  output logic [10:0] floor_row_o,
  output logic [4:0]  shade_level_o
);
  req_t        push_data, head;
  logic        push, full, empty, pop, idle;
  logic [15:0] px, py, va, fov;
  logic [10:0] sw, sh;
  logic [6:0]  mw, mh;

  grc_front u_front (
    .clk_i, .rst_ni, .start, .busy, .q_full_i(full), .push_o(push),
    .cmd_i, .cell_index_i, .cell_wall_i, .column_i, .push_data_o(push_data),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .player_x_o(px), .player_y_o(py), .view_angle_o(va), .fov_o(fov),
    .scr_w_o(sw), .scr_h_o(sh), .map_w_o(mw), .map_h_o(mh)
  );

  grc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .head_o(head)
  );

  grc_back u_back (
    .clk_i, .rst_ni, .req_valid_i(!empty), .req_i(head), .req_pop_o(pop),
    .player_x_i(px), .player_y_i(py), .view_angle_i(va), .fov_i(fov),
    .scr_w_i(sw), .scr_h_i(sh), .map_w_i(mw), .map_h_i(mh), .idle_o(idle),
    .res_valid_o(result_valid_o), .column_out_o, .hit_o, .step_count_o,
    .ceiling_row_o, .floor_row_o, .shade_level_o
  );

  // no pop from an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !empty)
    else $error("pop from empty queue");
  // a pop only happens while the back end is idle
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> idle)
    else $error("pop while back end busy");
  // a result strobe lasts one cycle
  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held");
endmodule

// File: design/grc_queue.sv
// Short request queue between the front and the back of the column engine.
module grc_queue import grc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output req_t head_o
);
  localparam int Aw = $clog2(QDepth);

  req_t             mem_q [QDepth];
  logic [Aw-1:0]    wp_q, rp_q;
  logic [Aw:0]      cnt_q;

  assign full_o  = (cnt_q == (Aw+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop_i);
    end
  end
endmodule

// File: design/grc_back.sv
// Back part: map store writes, angle division, ray march and slice division.
module grc_back import grc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  req_t        req_i,
  output logic        req_pop_o,
  input  logic [15:0] player_x_i,
  input  logic [15:0] player_y_i,
  input  logic [15:0] view_angle_i,
  input  logic [15:0] fov_i,
  input  logic [10:0] scr_w_i,
  input  logic [10:0] scr_h_i,
  input  logic [6:0]  map_w_i,
  input  logic [6:0]  map_h_i,
  output logic        idle_o,
  output logic        res_valid_o,
  output logic [9:0]  column_out_o,
  output logic        hit_o,
  output logic [7:0]  step_count_o,
  output logic [9:0]  ceiling_row_o,
  output logic [10:0] floor_row_o,
  output logic [4:0]  shade_level_o
);
  typedef enum logic [7:0] {
    SIdle  = 8'b00000001,
    SDiv1  = 8'b00000010,
    STrig  = 8'b00000100,
    SPos   = 8'b00001000,
    SRead  = 8'b00010000,
    SChk   = 8'b00100000,
    SDiv2  = 8'b01000000,
    SOut   = 8'b10000000
  } state_e;

  state_e      st_q;
  logic        map_q [MapCells];
  logic        rd_q;
  logic [9:0]  col_q;
  // shared restoring divider
  logic [26:0] num_q;
  logic [21:0] den_q;
  logic [21:0] rem_q;
  logic [4:0]  bit_q;
  logic [15:0] angle_q;
  logic [14:0] sx_q, sy_q;
  logic        nx_q, ny_q;
  logic [7:0]  n_q;
  logic [7:0]  rx_q, ry_q;        // |s|*n mod 160
  logic [15:0] oxw_q, oyw_q;      // floor(|s|*n/160), up to 25600
  logic        hit_q;
  logic        out_q;

  logic [21:0] trial;
  logic        ge;
  logic [7:0]  a8, a8c;
  logic [14:0] sv, cv;
  logic [15:0] sumx, sumy;
  logic [7:0]  qx, qy, rnx, rny;
  logic [19:0] pxw, pyw;
  logic [9:0]  cxw, cyw;
  logic [16:0] addr_w;
  logic        out_w;
  logic [10:0] sw_eff;
  logic [7:0]  n_fin;
  logic        done;
  logic [4:0]  shade;
  logic [9:0]  ceil_row;

  // one step of the shared divider
  always_comb begin
    trial = {rem_q[20:0], num_q[bit_q]};
    ge    = (trial >= den_q);
  end

  // angle sine lookup
  always_comb begin
    a8  = angle_q[15:8];
    a8c = a8 + 8'd64;
    sv  = qsin(a8[6]  ? 7'(7'd64 - {1'b0, a8[5:0]})  : {1'b0, a8[5:0]});
    cv  = qsin(a8c[6] ? 7'(7'd64 - {1'b0, a8c[5:0]}) : {1'b0, a8c[5:0]});
  end

  // offset increment: acc grows by |s| each step, track quotient by 160
  always_comb begin
    sumx = 16'(rx_q) + 16'(sx_q);
    sumy = 16'(ry_q) + 16'(sy_q);
    // |s| <= 16384 so at most 103 units of 160 per step
    qx  = 8'((32'(sumx) * 32'd26215) >> 22);
    if (16'(qx) * 16'd160 > sumx) qx = qx - 1'b1;
    else if (16'(qx + 1'b1) * 16'd160 <= sumx) qx = qx + 1'b1;
    qy  = 8'((32'(sumy) * 32'd26215) >> 22);
    if (16'(qy) * 16'd160 > sumy) qy = qy - 1'b1;
    else if (16'(qy + 1'b1) * 16'd160 <= sumy) qy = qy + 1'b1;
    rnx = 8'(sumx - 16'(qx) * 16'd160);
    rny = 8'(sumy - 16'(qy) * 16'd160);
  end

  // position of the current step, its cell and the out-of-map check
  always_comb begin
    pxw = nx_q ? 20'({4'd0, player_x_i}) - 20'(oxw_q) : 20'({4'd0, player_x_i}) + 20'(oxw_q);
    pyw = ny_q ? 20'({4'd0, player_y_i}) - 20'(oyw_q) : 20'({4'd0, player_y_i}) + 20'(oyw_q);
    cxw = pxw[19:10];
    cyw = pyw[19:10];
    addr_w = 17'(cyw) * 17'(map_w_i) + 17'(cxw);
    out_w = pxw[19] || pyw[19] || ({3'd0, cxw} >= {6'd0, map_w_i}) ||
            ({3'd0, cyw} >= {6'd0, map_h_i}) || (addr_w >= 17'(MapCells));
  end

  assign sw_eff = (scr_w_i == '0) ? 11'd1 : scr_w_i;
  // leaving the map reports full depth
  assign n_fin  = out_q ? 8'(StepLimit) : n_q;

  assign idle_o    = (st_q == SIdle);
  assign req_pop_o = (st_q == SIdle) && req_valid_i;

  // map store
  always_ff @(posedge clk_i) begin
    if (req_pop_o && req_i.cmd == CmdWrite) map_q[req_i.cell_index] <= req_i.cell_wall;
    if (st_q == SRead) rd_q <= map_q[addr_w[MapAw-1:0]];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= SIdle;
      col_q   <= '0;
      num_q   <= '0;
      den_q   <= '0;
      rem_q   <= '0;
      bit_q   <= '0;
      angle_q <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      nx_q    <= 1'b0;
      ny_q    <= 1'b0;
      n_q     <= '0;
      rx_q    <= '0;
      ry_q    <= '0;
      oxw_q   <= '0;
      oyw_q   <= '0;
      hit_q   <= 1'b0;
      out_q   <= 1'b0;
    end else begin
      unique case (st_q)
        SIdle: begin
          if (req_valid_i && req_i.cmd == CmdCast) begin
            col_q <= req_i.column;
            num_q <= 27'(req_i.column) * 27'(fov_i);
            den_q <= 22'(sw_eff);
            rem_q <= '0;
            bit_q <= 5'd26;
            st_q  <= SDiv1;
          end
        end
        SDiv1: begin
          rem_q <= ge ? trial - den_q : trial;
          num_q[bit_q] <= ge;
          if (bit_q == '0) st_q <= STrig;
          else bit_q <= bit_q - 1'b1;
        end
        STrig: begin
          angle_q <= 16'(view_angle_i - {1'b0, fov_i[15:1]} + num_q[15:0]);
          st_q <= SPos;
        end
        SPos: begin
          sy_q <= sv; ny_q <= a8[7] && (sv != '0);
          sx_q <= cv; nx_q <= a8c[7] && (cv != '0);
          rx_q <= '0; ry_q <= '0; oxw_q <= '0; oyw_q <= '0;
          n_q <= '0; hit_q <= 1'b0;
          st_q <= SChk;
        end
        SChk: begin
          // advance one step
          n_q <= n_q + 1'b1;
          rx_q <= rnx; ry_q <= rny;
          oxw_q <= oxw_q + 16'(qx);
          oyw_q <= oyw_q + 16'(qy);
          st_q <= SRead;
        end
        SRead: begin
          // map cell is registered into rd_q at the same edge as out_q
          out_q <= out_w;
          st_q  <= SOut;
        end
        SOut: begin
          if (out_q || rd_q || n_q == 8'(StepLimit)) begin
            hit_q <= out_q || rd_q;
            n_q   <= n_fin;
            num_q <= (n_fin > 8'd20) ? 27'(21'(scr_h_i) * 21'(n_fin - 8'd20)) : '0;
            den_q <= 22'({n_fin, 1'b0});
            rem_q <= '0;
            bit_q <= 5'd26;
            st_q  <= SDiv2;
          end else begin
            st_q <= SChk;
          end
        end
        SDiv2: begin
          rem_q <= ge ? trial - den_q : trial;
          num_q[bit_q] <= ge;
          if (bit_q == '0) st_q <= SIdle;
          else bit_q <= bit_q - 1'b1;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  // result strobe when the slice division completes
  assign done = (st_q == SDiv2) && (bit_q == '0);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_o <= 1'b0;
    else res_valid_o <= done;
  end

  // shade: largest k <= 19 with n*k < 250; quotient of the slice division
  always_comb begin
    shade = 5'(ShadeCount - 1);
    for (int k = ShadeCount - 1; k >= 0; k--) begin
      if (16'(n_q) * 16'(k) >= 16'(StepLimit)) shade = 5'(k - 1);
    end
    ceil_row = {num_q[9:1], ge};
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      column_out_o  <= col_q;
      hit_o         <= hit_q;
      step_count_o  <= n_q;
      ceiling_row_o <= ceil_row;
      floor_row_o   <= scr_h_i - 11'(ceil_row);
      shade_level_o <= shade;
    end
  end
endmodule

// File: design/grc_front.sv
// Front part: accepts commands and configuration writes, queues requests.
module grc_front import grc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        q_full_i,
  output logic        push_o,
  input  logic        cmd_i,
  input  logic [11:0] cell_index_i,
  input  logic        cell_wall_i,
  input  logic [9:0]  column_i,
  output req_t        push_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic [15:0] player_x_o,
  output logic [15:0] player_y_o,
  output logic [15:0] view_angle_o,
  output logic [15:0] fov_o,
  output logic [10:0] scr_w_o,
  output logic [10:0] scr_h_o,
  output logic [6:0]  map_w_o,
  output logic [6:0]  map_h_o
);
  assign busy        = q_full_i;
  assign push_o      = start && !q_full_i;
  assign push_data_o = '{cmd: cmd_i, cell_index: cell_index_i, cell_wall: cell_wall_i,
                         column: column_i};
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_o <= 16'd8192; player_y_o <= 16'd8192;
      view_angle_o <= 16'd16384; fov_o <= 16'd8192;
      scr_w_o <= 11'd80; scr_h_o <= 11'd24; map_w_o <= 7'd23; map_h_o <= 7'd23;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegPlayerX: player_x_o   <= cfg_data_i;
        RegPlayerY: player_y_o   <= cfg_data_i;
        RegView:    view_angle_o <= cfg_data_i;
        RegFov:     fov_o        <= cfg_data_i;
        RegScrW:    scr_w_o      <= cfg_data_i[10:0];
        RegScrH:    scr_h_o      <= cfg_data_i[10:0];
        RegMapW:    map_w_o      <= cfg_data_i[6:0];
        RegMapH:    map_h_o      <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end
endmodule

// File: tb/grc_cast_checker.sv
// Checker for the raycast column engine: tracks config and map, predicts casts, compares.
module grc_cast_checker import grc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        cmd_i,
  input  logic [11:0] cell_index_i,
  input  logic        cell_wall_i,
  input  logic [9:0]  column_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        result_valid_i,
  input  logic [9:0]  column_out_i,
  input  logic        hit_i,
  input  logic [7:0]  step_count_i,
  input  logic [9:0]  ceiling_row_i,
  input  logic [10:0] floor_row_i,
  input  logic [4:0]  shade_level_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [9:0]  column;
    logic        hit;
    logic [7:0]  steps;
    logic [9:0]  ceiling;
    logic [10:0] floor_r;
    logic [4:0]  shade;
  } column_slice_t;

  // quarter wave, 14 fraction bits
  int sine_tab [0:64] = '{
        0,   402,   804,  1205,  1606,  2006,  2404,  2801,
     3196,  3590,  3981,  4370,  4756,  5139,  5520,  5897,
     6270,  6639,  7005,  7366,  7723,  8076,  8423,  8765,
     9102,  9434,  9760, 10080, 10394, 10702, 11003, 11297,
    11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
    13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978,
    15137, 15286, 15426, 15557, 15679, 15791, 15893, 15986,
    16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379,
    16384};

  logic [15:0] pos_x, pos_y, heading, view_width;
  logic [10:0] scr_w, scr_h;
  logic [6:0]  grid_w, grid_h;
  logic        wall_map [MapCells];
  column_slice_t expected_slices [$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_slices.size();

  function automatic int trig(input logic [7:0] a8);
    int v;
    v = a8[6] ? sine_tab[64 - a8[5:0]] : sine_tab[a8[5:0]];
    return a8[7] ? -v : v;
  endfunction

  function automatic int step_offset(input int s, input int n);
    int mag;
    mag = ((s < 0) ? -s : s) * n / 160;
    return (s < 0) ? -mag : mag;
  endfunction

  // march the ray and shape the wall slice
  function automatic column_slice_t cast_column(input logic [9:0] col);
    column_slice_t r;
    logic [31:0] sw, ray;
    logic [7:0]  a8;
    int dx, dy, n, px, py, cx, cy, addr, ceil_v, shade_v;
    logic found;
    sw  = (scr_w == 0) ? 32'd1 : 32'(scr_w);
    ray = 32'(heading) - 32'(view_width >> 1) + (32'(col) * 32'(view_width)) / sw;
    a8  = ray[15:8];
    dy  = trig(a8);
    dx  = trig(a8 + 8'd64);
    n = 0;
    found = 1'b0;
    while (!found && n < StepLimit) begin
      n++;
      px = int'(pos_x) + step_offset(dx, n);
      py = int'(pos_y) + step_offset(dy, n);
      if (px < 0 || py < 0) begin
        found = 1'b1;
        n = StepLimit;
      end else begin
        cx = px >>> 10;
        cy = py >>> 10;
        addr = cy * int'(grid_w) + cx;
        if (cx >= int'(grid_w) || cy >= int'(grid_h) || addr >= MapCells) begin
          found = 1'b1;
          n = StepLimit;
        end else if (wall_map[addr]) begin
          found = 1'b1;
        end
      end
    end
    if (n == 0) n = 1;
    ceil_v  = (n > 20) ? int'(scr_h) * (n - 20) / (2 * n) : 0;
    shade_v = (StepLimit - 1) / n;
    if (shade_v > ShadeCount - 1) shade_v = ShadeCount - 1;
    r.column  = col;
    r.hit     = found;
    r.steps   = n[7:0];
    r.ceiling = ceil_v[9:0];
    r.floor_r = 11'(int'(scr_h) - ceil_v);
    r.shade   = shade_v[4:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  initial fails = 0;

  // results first, then new requests and register writes
  always @(posedge clk_i or negedge rst_ni) begin
    column_slice_t w;
    if (!rst_ni) begin
      pos_x <= 16'd8192; pos_y <= 16'd8192; heading <= 16'd16384; view_width <= 16'd8192;
      scr_w <= 11'd80; scr_h <= 11'd24; grid_w <= 7'd23; grid_h <= 7'd23;
      expected_slices.delete();
    end else begin
      if (result_valid_i) begin
        if (expected_slices.size() == 0) begin
          report_mismatch("unexpected result, column", column_out_i, -1);
        end else begin
          w = expected_slices.pop_front();
          if (column_out_i  !== w.column)  report_mismatch("column", column_out_i, w.column);
          if (hit_i         !== w.hit)     report_mismatch("hit", hit_i, w.hit);
          if (step_count_i  !== w.steps)   report_mismatch("steps", step_count_i, w.steps);
          if (ceiling_row_i !== w.ceiling) report_mismatch("ceiling", ceiling_row_i, w.ceiling);
          if (floor_row_i   !== w.floor_r) report_mismatch("floor", floor_row_i, w.floor_r);
          if (shade_level_i !== w.shade)   report_mismatch("shade", shade_level_i, w.shade);
        end
      end
      if (start_i && !busy_i) begin
        if (cmd_i == CmdCast) expected_slices.push_back(cast_column(column_i));
        else wall_map[cell_index_i] = cell_wall_i;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegPlayerX: pos_x      <= cfg_data_i;
          RegPlayerY: pos_y      <= cfg_data_i;
          RegView:    heading    <= cfg_data_i;
          RegFov:     view_width <= cfg_data_i;
          RegScrW:    scr_w      <= cfg_data_i[10:0];
          RegScrH:    scr_h      <= cfg_data_i[10:0];
          RegMapW:    grid_w     <= cfg_data_i[6:0];
          RegMapH:    grid_h     <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/grid_raycast_column_tb.sv
// Top of the raycast column testbench: clock, reset, request and register stimulus, verdict.
module grid_raycast_column_tb;
  import grc_pkg::*;

  // cells loaded up front; every random map spans no more than this
  localparam int FillCells = 23 * 23;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd = CmdWrite;
  logic [11:0] cell_index = '0;
  logic        cell_wall = 1'b0;
  logic [9:0]  column = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = RegPlayerX;
  logic [15:0] cfg_data = '0;
  logic        res_valid;
  logic [9:0]  res_column;
  logic        res_hit;
  logic [7:0]  res_steps;
  logic [9:0]  res_ceiling;
  logic [10:0] res_floor;
  logic [4:0]  res_shade;
  int          fail_count, pending;
  int          burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grid_raycast_column u_dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .cmd_i(cmd), .cell_index_i(cell_index), .cell_wall_i(cell_wall), .column_i(column),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .result_valid_o(res_valid), .column_out_o(res_column),
    .hit_o(res_hit), .step_count_o(res_steps), .ceiling_row_o(res_ceiling),
    .floor_row_o(res_floor), .shade_level_o(res_shade)
  );

  grc_cast_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .cmd_i(cmd), .cell_index_i(cell_index), .cell_wall_i(cell_wall), .column_i(column),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data), .result_valid_i(res_valid), .column_out_i(res_column),
    .hit_i(res_hit), .step_count_i(res_steps), .ceiling_row_i(res_ceiling),
    .floor_row_i(res_floor), .shade_level_i(res_shade),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // one request; start stays high until a gap lowers it
  task automatic send_req(input logic c, input logic [11:0] idx, input logic wall,
                          input logic [9:0] col);
    start <= 1'b1; cmd <= c; cell_index <= idx; cell_wall <= wall; column <= col;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 300 : 12)) @(posedge clk);
      end
    end
  endtask

  task automatic cast(input logic [9:0] col);
    send_req(CmdCast, 12'($urandom), 1'($urandom), col);
  endtask

  task automatic put_cell(input logic [11:0] idx, input logic wall);
    send_req(CmdWrite, idx, wall, 10'($urandom));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // idle the engine, then load every register
  task automatic set_view(input logic [15:0] px, input logic [15:0] py, input logic [15:0] va,
                          input logic [15:0] fov, input logic [10:0] sw, input logic [10:0] sh,
                          input logic [6:0] mw, input logic [6:0] mh);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    write_reg(RegPlayerX, px);
    write_reg(RegPlayerY, py);
    write_reg(RegView, va);
    write_reg(RegFov, fov);
    write_reg(RegScrW, 16'(sw));
    write_reg(RegScrH, 16'(sh));
    write_reg(RegMapW, 16'(mw));
    write_reg(RegMapH, 16'(mh));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random view over a map of at most FillCells cells, so rays only read loaded cells
  task automatic random_view();
    logic [6:0] mw, mh;
    int span_x, span_y, mh_top;
    mw = 7'($urandom_range(1, 64));
    mh_top = FillCells / int'(mw);
    if (mh_top > 64) mh_top = 64;
    mh = 7'($urandom_range(1, mh_top));
    // now and then an empty map, where every cell lies outside
    if ($urandom_range(0, 7) == 0) mw = 7'd0;
    else if ($urandom_range(0, 7) == 0) mh = 7'd0;
    span_x = (mw == 0) ? 65535 : ((mw * 1024 > 65535) ? 65535 : mw * 1024 - 1);
    span_y = (mh == 0) ? 65535 : ((mh * 1024 > 65535) ? 65535 : mh * 1024 - 1);
    set_view(16'($urandom_range(0, span_x)), 16'($urandom_range(0, span_y)), 16'($urandom),
             16'($urandom_range(0, 32768)),
             ($urandom_range(0, 5) == 0) ? 11'($urandom) : 11'($urandom_range(1, 1024)),
             ($urandom_range(0, 5) == 0) ? 11'($urandom) : 11'($urandom_range(1, 1024)),
             mw, mh);
  endtask

  initial begin : limit_guard
    #60000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the cells that rays of the reset and random views can read; the first 64 cells kept open
    for (int i = 0; i < FillCells; i++)
      put_cell(12'(i), (i < 64) ? 1'b0 : ($urandom_range(0, 5) == 0));

    // reset view: edge columns, a column past the width, writes at the store ends
    cast(10'd0);
    cast(10'd79);
    cast(10'd1023);
    put_cell(12'd4095, 1'b1);
    put_cell(12'd0, 1'b0);
    cast(10'd40);

    // open row along +x: no wall within depth; zero screen width
    set_view(16'd512, 16'd512, 16'd0, 16'd0, 11'd0, 11'd1024, 7'd64, 7'd64);
    cast(10'd0);
    cast(10'd1023);
    // facing -x from the origin: position goes negative
    set_view(16'd0, 16'd0, 16'd32768, 16'd0, 11'd1, 11'd1, 7'd64, 7'd64);
    cast(10'd0);
    cast(10'd512);
    // zero map size: every cell outside
    set_view(16'd2048, 16'd2048, 16'd100, 16'd32768, 11'd1024, 11'd0, 7'd0, 7'd0);
    cast(10'd3);
    // widest settings, far corner
    set_view(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd32768, 11'd2047, 11'd2047, 7'd127, 7'd127);
    cast(10'd0);
    cast(10'd1023);
    set_view(16'd10000, 16'd20000, 16'd49152, 16'd32768, 11'd1024, 11'd2047, 7'd23, 7'd23);
    cast(10'd0);
    cast(10'd700);
    cast(10'd1023);

    // random part, new view every few dozen requests
    for (int k = 0; k < 260; k++) begin
      if (k % 60 == 0) random_view();
      if ($urandom_range(0, 99) < 65) begin
        if ($urandom_range(0, 4) == 0) cast(10'($urandom));
        else cast(10'($urandom_range(0, 1023)));
      end else begin
        put_cell(12'($urandom), ($urandom_range(0, 3) == 0));
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
